FILE: hw/rtl/ptls_pkg.sv
// ----------------------------------------------------------------------------
// ptls_pkg
// Shared types and constants of the presence triggered loader sequencer.
// ----------------------------------------------------------------------------
package ptls_pkg;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 11;
    localparam int OUT_DATA_W = 24;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_THRESHOLD  = 3'd0,
        CFG_RAISED     = 3'd1,
        CFG_LOADING    = 3'd2,
        CFG_DWELL      = 3'd3,
        CFG_MOTOR      = 3'd4,
        CFG_LOAD_CHK   = 3'd5,
        CFG_DEPARTURE  = 3'd6
    } cfg_addr_t;

    localparam logic [10:0] RST_THRESHOLD = 11'd103;
    localparam logic [7:0]  RST_RAISED    = 8'd125;
    localparam logic [7:0]  RST_LOADING   = 8'd75;
    localparam logic [7:0]  RST_DWELL     = 8'd25;
    localparam logic [7:0]  RST_MOTOR     = 8'd175;
    localparam logic [7:0]  RST_LOAD_CHK  = 8'd100;
    localparam logic [3:0]  RST_DEPARTURE = 4'd10;

    localparam logic [8:0] DWELL_MAX   = 9'd511;
    localparam logic [7:0] CHECK_MAX   = 8'd255;
    localparam logic [3:0] ABSENT_MAX  = 4'd15;

    typedef struct packed {
        logic [10:0] presence_threshold;
        logic [7:0]  raised_position;
        logic [7:0]  loading_position;
        logic [7:0]  dwell_ticks;
        logic [7:0]  drive_level;
        logic [7:0]  load_checks;
        logic [3:0]  departure_count;
    } cfg_t;

    typedef enum logic [4:0] {
        PH_IDLE  = 5'b00001,
        PH_LOWER = 5'b00010,
        PH_LOAD  = 5'b00100,
        PH_RAISE = 5'b01000,
        PH_WAIT  = 5'b10000
    } phase_t;

    localparam logic [2:0] CODE_IDLE  = 3'd0;
    localparam logic [2:0] CODE_LOWER = 3'd1;
    localparam logic [2:0] CODE_LOAD  = 3'd2;
    localparam logic [2:0] CODE_RAISE = 3'd3;
    localparam logic [2:0] CODE_WAIT  = 3'd4;

    typedef struct packed {
        logic [2:0] phase;
        logic       presence_led;
        logic [7:0] motor_drive;
        logic       servo_enabled;
        logic [7:0] servo_angle;
    } result_t;

endpackage

FILE: hw/rtl/ptls_cfg.sv
// ----------------------------------------------------------------------------
// ptls_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module ptls_cfg
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [ptls_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [ptls_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output ptls_pkg::cfg_t                    cfg
);
    import ptls_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_addr_t'(cfg_addr))
                CFG_THRESHOLD: cfg_next.presence_threshold = cfg_wdata;
                CFG_RAISED:    cfg_next.raised_position    = cfg_wdata[7:0];
                CFG_LOADING:   cfg_next.loading_position   = cfg_wdata[7:0];
                CFG_DWELL:     cfg_next.dwell_ticks        = cfg_wdata[7:0];
                CFG_MOTOR:     cfg_next.drive_level        = cfg_wdata[7:0];
                CFG_LOAD_CHK:  cfg_next.load_checks        = cfg_wdata[7:0];
                CFG_DEPARTURE: cfg_next.departure_count    = cfg_wdata[3:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.presence_threshold <= RST_THRESHOLD;
            cfg_reg.raised_position    <= RST_RAISED;
            cfg_reg.loading_position   <= RST_LOADING;
            cfg_reg.dwell_ticks        <= RST_DWELL;
            cfg_reg.drive_level        <= RST_MOTOR;
            cfg_reg.load_checks        <= RST_LOAD_CHK;
            cfg_reg.departure_count    <= RST_DEPARTURE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: hw/rtl/ptls_core.sv
// ----------------------------------------------------------------------------
// ptls_core
// Sequencer state and the per-tick update, one sample per accepted item.
// ----------------------------------------------------------------------------
module ptls_core
#(
    parameter int TICKS_PER_CHECK = 4,
    parameter int SAMPLE_BITS     = 10
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  ptls_pkg::cfg_t         cfg,
    input  logic                   accept,
    input  logic [SAMPLE_BITS-1:0] sample,
    output ptls_pkg::result_t      result
);
    import ptls_pkg::*;

    localparam int SUB_W = (TICKS_PER_CHECK > 1) ? $clog2(TICKS_PER_CHECK) : 1;
    localparam int CMP_W = (SAMPLE_BITS > CFG_DATA_W) ? SAMPLE_BITS : CFG_DATA_W;
    localparam logic [SUB_W:0] TICKS_END = (SUB_W+1)'(TICKS_PER_CHECK);

    phase_t           phase_reg,    phase_next;
    logic [8:0]       dwell_reg,    dwell_next;
    logic [7:0]       servo_reg,    servo_next;
    logic [7:0]       check_reg,    check_next;
    logic [SUB_W-1:0] sub_reg,      sub_next;
    logic [3:0]       absent_reg,   absent_next;
    logic             led_reg,      led_next;
    logic [7:0]       angle_reg,    angle_next;

    logic             present;
    logic             sub_zero;
    logic [SUB_W:0]   sub_inc;
    logic             period_end;
    logic [8:0]       dwell_inc;
    logic [7:0]       check_inc;
    logic [3:0]       absent_inc;
    logic [2:0]       phase_code;
    logic             enabled;
    logic [7:0]       motor;

    assign present    = CMP_W'(sample) < CMP_W'(cfg.presence_threshold);
    assign sub_zero   = (sub_reg == '0);
    assign sub_inc    = {1'b0, sub_reg} + (SUB_W+1)'(1);
    assign period_end = (sub_inc >= TICKS_END);

    always_comb
    begin
        phase_next  = phase_reg;
        dwell_next  = dwell_reg;
        servo_next  = servo_reg;
        check_next  = check_reg;
        sub_next    = sub_reg;
        absent_next = absent_reg;
        led_next    = led_reg;
        angle_next  = angle_reg;
        dwell_inc   = dwell_reg;
        check_inc   = check_reg;
        absent_inc  = absent_reg;
        phase_code  = CODE_IDLE;
        enabled     = 1'b0;
        motor       = '0;

        unique case (phase_reg)
            PH_LOWER:
            begin
                phase_code = CODE_LOWER;
                enabled    = 1'b1;
                if (servo_reg < cfg.loading_position)
                begin
                    phase_next = PH_LOAD;
                end
                else if (!present)
                begin
                    led_next   = 1'b0;
                    phase_next = PH_RAISE;
                end
                else
                begin
                    led_next   = 1'b1;
                    angle_next = servo_reg;
                    if (servo_reg != '0)
                        servo_next = servo_reg - 8'd1;
                    if (servo_reg <= cfg.loading_position)
                        phase_next = PH_LOAD;
                end
                if (phase_next == PH_LOAD)
                begin
                    check_next = '0;
                    sub_next   = '0;
                end
            end
            PH_LOAD:
            begin
                phase_code = CODE_LOAD;
                enabled    = 1'b1;
                motor      = cfg.drive_level;
                if (sub_zero && (check_reg >= cfg.load_checks))
                begin
                    motor      = '0;
                    phase_next = PH_RAISE;
                end
                else if (sub_zero && !present)
                begin
                    led_next   = 1'b0;
                    motor      = '0;
                    phase_next = PH_RAISE;
                end
                else
                begin
                    if (sub_zero)
                    begin
                        led_next = 1'b1;
                        if (check_reg != CHECK_MAX)
                            check_inc = check_reg + 8'd1;
                    end
                    check_next = check_inc;
                    sub_next   = period_end ? '0 : sub_inc[SUB_W-1:0];
                    if (period_end && (check_inc >= cfg.load_checks))
                        phase_next = PH_RAISE;
                end
            end
            PH_RAISE:
            begin
                phase_code = CODE_RAISE;
                enabled    = 1'b1;
                if (servo_reg > cfg.raised_position)
                begin
                    phase_next = PH_WAIT;
                end
                else
                begin
                    angle_next = servo_reg;
                    if (servo_reg >= cfg.raised_position)
                        phase_next = PH_WAIT;
                    else
                        servo_next = servo_reg + 8'd1;
                end
                if (phase_next == PH_WAIT)
                begin
                    absent_next = '0;
                    sub_next    = '0;
                end
            end
            PH_WAIT:
            begin
                phase_code = CODE_WAIT;
                if (sub_zero && (absent_reg >= cfg.departure_count))
                begin
                    phase_next = PH_IDLE;
                end
                else
                begin
                    if (sub_zero)
                    begin
                        led_next = present;
                        if (!present && (absent_reg != ABSENT_MAX))
                            absent_inc = absent_reg + 4'd1;
                    end
                    absent_next = absent_inc;
                    sub_next    = period_end ? '0 : sub_inc[SUB_W-1:0];
                    if (period_end && (absent_inc >= cfg.departure_count))
                        phase_next = PH_IDLE;
                end
                if (phase_next == PH_IDLE)
                    dwell_next = '0;
            end
            default:
            begin
                phase_code = CODE_IDLE;
                led_next   = present;
                if (present)
                begin
                    if (dwell_reg != DWELL_MAX)
                        dwell_inc = dwell_reg + 9'd1;
                end
                else
                begin
                    dwell_inc = '0;
                end
                if (dwell_inc > {1'b0, cfg.dwell_ticks})
                begin
                    dwell_next = '0;
                    servo_next = cfg.raised_position;
                    phase_next = PH_LOWER;
                end
                else
                begin
                    dwell_next = dwell_inc;
                    phase_next = PH_IDLE;
                end
            end
        endcase

        result.servo_angle   = angle_next;
        result.servo_enabled = enabled;
        result.motor_drive   = motor;
        result.presence_led  = led_next;
        result.phase         = phase_code;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            dwell_reg  <= '0;
            servo_reg  <= RST_RAISED;
            check_reg  <= '0;
            sub_reg    <= '0;
            absent_reg <= '0;
            led_reg    <= 1'b0;
            angle_reg  <= RST_RAISED;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            dwell_reg  <= dwell_next;
            servo_reg  <= servo_next;
            check_reg  <= check_next;
            sub_reg    <= sub_next;
            absent_reg <= absent_next;
            led_reg    <= led_next;
            angle_reg  <= angle_next;
        end
    end

endmodule

FILE: hw/rtl/ptls_out_buf.sv
// ----------------------------------------------------------------------------
// ptls_out_buf
// Result register with a skid stage, so input stays open in the first stall cycle.
// ----------------------------------------------------------------------------
module ptls_out_buf
#(
    parameter int WIDTH = 24
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);
    logic             main_valid_reg;
    logic             skid_valid_reg;
    logic [WIDTH-1:0] main_data_reg;
    logic [WIDTH-1:0] skid_data_reg;
    logic             push;
    logic             load_main;

    assign in_ready  = !skid_valid_reg;
    assign push      = in_valid && in_ready;
    assign load_main = !main_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (load_main)
        begin
            main_valid_reg <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_main)
            main_data_reg <= skid_valid_reg ? skid_data_reg : in_data;
        else if (push)
            skid_data_reg <= in_data;
    end

    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;

endmodule

FILE: hw/rtl/presence_triggered_loader_sequencer_top.sv
// ----------------------------------------------------------------------------
// presence_triggered_loader_sequencer_top
// Loader sequencer: one hall sample per tick in, one actuator result out.
// ----------------------------------------------------------------------------
//  channel   | handshake                   | contents
//  s_axis    | s_axis_tvalid/s_axis_tready | hall_sample
//  m_axis    | m_axis_tvalid/m_axis_tready | servo_angle .. phase
//  cfg       | cfg_we                      | cfg_addr, cfg_wdata
//
//  one item per cycle while s_axis_tready is high; its result is registered in the output buffer
//  the sequencer state updates in the cycle the item is accepted
//  a two-entry output buffer keeps s_axis_tready high in the first stall cycle
//  s_axis_tready then stays low until m_axis_tready returns and the skid entry moves on
//  reset restores all register defaults and returns the sequencer to idle
// ----------------------------------------------------------------------------
module presence_triggered_loader_sequencer_top
#(
    parameter int TICKS_PER_CHECK = 4,
    parameter int SAMPLE_BITS     = 10
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    // hall_sample
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      s_axis_tdata,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // servo_angle, servo_enabled, motor_drive, presence_led, phase
    output logic [ptls_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    input  logic                                  cfg_we,
    input  logic [ptls_pkg::CFG_ADDR_W-1:0]       cfg_addr,
    input  logic [ptls_pkg::CFG_DATA_W-1:0]       cfg_wdata
);
    import ptls_pkg::*;

    localparam int RES_W = $bits(result_t);

    cfg_t                  cfg;
    result_t               result;
    logic                  accept;
    logic [OUT_DATA_W-1:0] result_data;

    assign accept      = s_axis_tvalid && s_axis_tready;
    assign result_data = {(OUT_DATA_W-RES_W)'(0), result};

    ptls_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    ptls_core
    #(
        .TICKS_PER_CHECK (TICKS_PER_CHECK),
        .SAMPLE_BITS     (SAMPLE_BITS)
    )
    u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .accept (accept),
        .sample (s_axis_tdata[SAMPLE_BITS-1:0]),
        .result (result)
    );

    ptls_out_buf
    #(
        .WIDTH (OUT_DATA_W)
    )
    u_out_buf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (result_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule

FILE: hw/rtl/ptls_checker.sv
// ----------------------------------------------------------------------------
// ptls_checker
// Port-level checks of the loader sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module ptls_checker
(
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_axis_tready,
    input logic [ptls_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready
);
    import ptls_pkg::*;

    logic [2:0] phase;
    logic [7:0] motor;
    logic       enabled;

    assign phase   = m_axis_tdata[20:18];
    assign motor   = m_axis_tdata[16:9];
    assign enabled = m_axis_tdata[8];

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // input only closes while results are backed up
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input closed with empty output");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> phase == CODE_IDLE || phase == CODE_LOWER
            || phase == CODE_LOAD || phase == CODE_RAISE || phase == CODE_WAIT)
        else $error("phase code out of range");

    // conveyor only runs while loading
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (motor != 8'd0) |-> phase == CODE_LOAD)
        else $error("motor driven outside loading");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> enabled == (phase == CODE_LOWER || phase == CODE_LOAD
            || phase == CODE_RAISE))
        else $error("servo enable does not match phase");

endmodule

bind presence_triggered_loader_sequencer_top ptls_checker u_ptls_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
);

FILE: bench/ptls_actuation_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ptls_actuation_checker
// Watches the sample, result and register channels of the loader sequencer,
// tracks the register settings and the sequencer state on its own, works out
// the actuator result of every accepted sample and compares it field by
// field with the result items that leave the block, in order.
// ----------------------------------------------------------------------------
module ptls_actuation_checker
#(
    parameter int TICKS_PER_CHECK = 4,
    parameter int SAMPLE_BITS     = 10
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      s_axis_tdata,
    input  logic                                  s_axis_tvalid,
    input  logic                                  s_axis_tready,
    input  logic [ptls_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
    input  logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    input  logic                                  cfg_we,
    input  logic [ptls_pkg::CFG_ADDR_W-1:0]       cfg_addr,
    input  logic [ptls_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    output int unsigned                           outstanding,
    output int unsigned                           mismatches
);
    import ptls_pkg::*;

    localparam int PRINT_CAP = 100;

    cfg_t        settings;
    logic [2:0]  seq_phase;
    logic [8:0]  dwell_cnt;
    logic [7:0]  servo_next;
    logic [7:0]  angle_shown;
    logic [7:0]  checks_done;
    int          sub_cnt;
    logic [3:0]  absent_cnt;
    logic        led;

    result_t     actuation_q[$];
    int unsigned error_cnt;

    task automatic report_mismatch(input string msg);
        if (error_cnt < PRINT_CAP)
            $display("%0t ns  mismatch: %s", $time, msg);
        error_cnt++;
    endtask

    function automatic logic sense(input logic [SAMPLE_BITS-1:0] smp);
        led = ({1'b0, smp} < settings.presence_threshold);
        return led;
    endfunction

    // true when the tick ends a check period
    function automatic logic period_done();
        if (sub_cnt >= TICKS_PER_CHECK - 1)
        begin
            sub_cnt = 0;
            return 1'b1;
        end
        sub_cnt++;
        return 1'b0;
    endfunction

    function automatic result_t sequence_tick(input logic [SAMPLE_BITS-1:0] smp);
        logic [2:0] cur;
        logic [2:0] nxt;
        logic       en;
        logic [7:0] motor;
        logic       last_step;
        result_t    res;
        cur   = seq_phase;
        nxt   = cur;
        en    = 1'b0;
        motor = '0;
        case (cur)
            CODE_LOWER:
            begin
                en = 1'b1;
                if (servo_next < settings.loading_position)
                    nxt = CODE_LOAD;
                else if (!sense(smp))
                    nxt = CODE_RAISE;
                else
                begin
                    last_step   = (servo_next <= settings.loading_position);
                    angle_shown = servo_next;
                    if (servo_next != 0)
                        servo_next = servo_next - 8'd1;
                    if (last_step)
                        nxt = CODE_LOAD;
                end
                if (nxt == CODE_LOAD)
                begin
                    checks_done = '0;
                    sub_cnt     = 0;
                end
            end
            CODE_LOAD:
            begin
                en    = 1'b1;
                motor = settings.drive_level;
                if (sub_cnt == 0 && checks_done >= settings.load_checks)
                begin
                    motor = '0;
                    nxt   = CODE_RAISE;
                end
                else if (sub_cnt == 0 && !sense(smp))
                begin
                    motor = '0;
                    nxt   = CODE_RAISE;
                end
                else
                begin
                    if (sub_cnt == 0 && checks_done < CHECK_MAX)
                        checks_done = checks_done + 8'd1;
                    if (period_done() && checks_done >= settings.load_checks)
                        nxt = CODE_RAISE;
                end
            end
            CODE_RAISE:
            begin
                en = 1'b1;
                if (servo_next > settings.raised_position)
                    nxt = CODE_WAIT;
                else
                begin
                    angle_shown = servo_next;
                    if (servo_next >= settings.raised_position)
                        nxt = CODE_WAIT;
                    else
                        servo_next = servo_next + 8'd1;
                end
                if (nxt == CODE_WAIT)
                begin
                    absent_cnt = '0;
                    sub_cnt    = 0;
                end
            end
            CODE_WAIT:
            begin
                if (sub_cnt == 0 && absent_cnt >= settings.departure_count)
                    nxt = CODE_IDLE;
                else
                begin
                    if (sub_cnt == 0)
                    begin
                        if (!sense(smp) && absent_cnt < ABSENT_MAX)
                            absent_cnt = absent_cnt + 4'd1;
                    end
                    if (period_done() && absent_cnt >= settings.departure_count)
                        nxt = CODE_IDLE;
                end
                if (nxt == CODE_IDLE)
                    dwell_cnt = '0;
            end
            default:
            begin
                cur = CODE_IDLE;
                if (sense(smp))
                begin
                    if (dwell_cnt < DWELL_MAX)
                        dwell_cnt = dwell_cnt + 9'd1;
                end
                else
                    dwell_cnt = '0;
                if (dwell_cnt > settings.dwell_ticks)
                begin
                    dwell_cnt  = '0;
                    servo_next = settings.raised_position;
                    nxt        = CODE_LOWER;
                end
                else
                    nxt = CODE_IDLE;
            end
        endcase
        seq_phase = nxt;
        res.servo_angle   = angle_shown;
        res.servo_enabled = en;
        res.motor_drive   = motor;
        res.presence_led  = led;
        res.phase         = cur;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t got;
        result_t want;
        if (!rst_n)
        begin
            settings = '{presence_threshold: RST_THRESHOLD, raised_position: RST_RAISED,
                         loading_position: RST_LOADING, dwell_ticks: RST_DWELL,
                         drive_level: RST_MOTOR, load_checks: RST_LOAD_CHK,
                         departure_count: RST_DEPARTURE};
            seq_phase   = CODE_IDLE;
            dwell_cnt   = '0;
            servo_next  = RST_RAISED;
            angle_shown = RST_RAISED;
            checks_done = '0;
            sub_cnt     = 0;
            absent_cnt  = '0;
            led         = 1'b0;
            actuation_q.delete();
            error_cnt   = 0;
            outstanding <= 0;
            mismatches  <= 0;
        end
        else
        begin
            // an item accepted at a register write still sees the old settings
            if (s_axis_tvalid === 1'b1 && s_axis_tready === 1'b1)
                actuation_q.push_back(sequence_tick(s_axis_tdata[SAMPLE_BITS-1:0]));
            if (cfg_we === 1'b1)
            begin
                case (cfg_addr_t'(cfg_addr))
                    CFG_THRESHOLD: settings.presence_threshold = cfg_wdata;
                    CFG_RAISED:    settings.raised_position    = cfg_wdata[7:0];
                    CFG_LOADING:   settings.loading_position   = cfg_wdata[7:0];
                    CFG_DWELL:     settings.dwell_ticks        = cfg_wdata[7:0];
                    CFG_MOTOR:     settings.drive_level        = cfg_wdata[7:0];
                    CFG_LOAD_CHK:  settings.load_checks        = cfg_wdata[7:0];
                    CFG_DEPARTURE: settings.departure_count    = cfg_wdata[3:0];
                    default: ;
                endcase
            end
            if (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)
            begin
                got = result_t'(m_axis_tdata[$bits(result_t)-1:0]);
                if (actuation_q.size() == 0)
                    report_mismatch($sformatf("result item %h with none outstanding",
                                              m_axis_tdata));
                else
                begin
                    want = actuation_q.pop_front();
                    if (got.servo_angle !== want.servo_angle)
                        report_mismatch($sformatf("servo_angle got %0d expected %0d",
                                                  got.servo_angle, want.servo_angle));
                    if (got.servo_enabled !== want.servo_enabled)
                        report_mismatch($sformatf("servo_enabled got %0d expected %0d",
                                                  got.servo_enabled, want.servo_enabled));
                    if (got.motor_drive !== want.motor_drive)
                        report_mismatch($sformatf("motor_drive got %0d expected %0d",
                                                  got.motor_drive, want.motor_drive));
                    if (got.presence_led !== want.presence_led)
                        report_mismatch($sformatf("presence_led got %0d expected %0d",
                                                  got.presence_led, want.presence_led));
                    if (got.phase !== want.phase)
                        report_mismatch($sformatf("phase got %0d expected %0d",
                                                  got.phase, want.phase));
                end
            end
            outstanding <= actuation_q.size();
            mismatches  <= error_cnt;
        end
    end

endmodule

FILE: bench/tb_presence_triggered_loader_sequencer_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_presence_triggered_loader_sequencer_top
// Drives hall samples through the loader sequencer: a short directed run over
// field extremes, threshold edges and the corner sequences, then random runs
// of mostly present, mostly absent or mixed samples under changing register
// settings, with bursty input and a stalling result receiver. The checker
// beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_presence_triggered_loader_sequencer_top;
    import ptls_pkg::*;

    localparam int          TICKS_PER_CHECK = 4;
    localparam int          SAMPLE_BITS     = 10;
    localparam int          IN_W            = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int          CLK_PERIOD      = 4;
    localparam int          RANDOM_ITEMS    = 1300;
    localparam int unsigned CYCLE_LIMIT     = 400000;

    typedef enum int {RUN_PRESENT, RUN_ABSENT, RUN_NOISE} run_kind_t;
    typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic [IN_W-1:0]       s_axis_tdata;       // hall_sample
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    // servo_angle, servo_enabled, motor_drive, presence_led, phase
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    int unsigned outstanding;
    int unsigned mismatches;
    int unsigned cycles = 0;

    int        burst_left;
    int        thr_now;
    int        raised_now;
    run_kind_t run_kind;
    int        run_left;
    rx_mode_t  rx_mode;
    int        rx_left;

    always #(CLK_PERIOD / 2) clk = ~clk;

    presence_triggered_loader_sequencer_top
    #(
        .TICKS_PER_CHECK (TICKS_PER_CHECK),
        .SAMPLE_BITS     (SAMPLE_BITS)
    )
    DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    ptls_actuation_checker
    #(
        .TICKS_PER_CHECK (TICKS_PER_CHECK),
        .SAMPLE_BITS     (SAMPLE_BITS)
    )
    u_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .outstanding   (outstanding),
        .mismatches    (mismatches)
    );

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("** presence_triggered_loader_sequencer_top: FAILED **");
            $finish;
        end
    end

    // result receiver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            rx_mode       <= RX_FREE;
            rx_left       <= 0;
        end
        else
        begin
            if (rx_left == 0)
            begin
                rx_mode <= rx_mode_t'($urandom_range(RX_PERIODIC, RX_FREE));
                rx_left <= $urandom_range(120, 8);
            end
            else
                rx_left <= rx_left - 1;
            case (rx_mode)
                RX_FREE:     m_axis_tready <= 1'b1;
                RX_LIGHT:    m_axis_tready <= ($urandom_range(3, 0) != 0);
                RX_HEAVY:    m_axis_tready <= ($urandom_range(9, 0) < 3);
                default:     m_axis_tready <= (cycles % 5 == 0);
            endcase
        end
    end

    task automatic push_sample(input logic [SAMPLE_BITS-1:0] smp);
        int gap;
        s_axis_tdata  <= {{(IN_W - SAMPLE_BITS){1'b0}}, smp};
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (s_axis_tready !== 1'b1);
        if (burst_left != 0)
            burst_left--;
        else
        begin
            burst_left = ($urandom_range(3, 0) == 0) ? $urandom_range(120, 40)
                                                      : $urandom_range(20, 1);
            gap = $urandom_range(8, 1);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // stop sending and wait for every outstanding result item
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    task automatic write_reg(input cfg_addr_t idx, input int val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= CFG_DATA_W'(val);
        if (idx == CFG_THRESHOLD)
            thr_now = val;
        if (idx == CFG_RAISED)
            raised_now = val;
        @(posedge clk);
    endtask

    function automatic int pick(input int lo, input int hi, input int ext_lo, input int ext_hi);
        int r;
        r = $urandom_range(9, 0);
        if (r == 0)
            return ext_lo;
        if (r == 1)
            return ext_hi;
        return $urandom_range(hi, lo);
    endfunction

    task automatic retune();
        bit wrote;
        int lvl;
        wrote = 1'b0;
        if ($urandom_range(2, 0) == 0)
        begin
            write_reg(CFG_THRESHOLD, pick(64, 960, 0, 1024));
            wrote = 1'b1;
        end
        if ($urandom_range(2, 0) == 0)
        begin
            write_reg(CFG_RAISED, pick(0, 180, 0, 180));
            wrote = 1'b1;
        end
        if ($urandom_range(2, 0) == 0)
        begin
            lvl = raised_now - $urandom_range(10, 0);
            if (lvl < 0)
                lvl = 0;
            write_reg(CFG_LOADING, pick(lvl, lvl, 0, 180));
            wrote = 1'b1;
        end
        if ($urandom_range(2, 0) == 0)
        begin
            write_reg(CFG_MOTOR, pick(1, 254, 0, 255));
            wrote = 1'b1;
        end
        if ($urandom_range(2, 0) == 0)
        begin
            write_reg(CFG_LOAD_CHK, pick(1, 6, 0, 255));
            wrote = 1'b1;
        end
        if ($urandom_range(2, 0) == 0)
        begin
            write_reg(CFG_DEPARTURE, pick(1, 4, 0, 15));
            wrote = 1'b1;
        end
        if (!wrote || $urandom_range(2, 0) == 0)
            write_reg(CFG_DWELL, pick(0, 6, 0, 255));
        cfg_we <= 1'b0;
    endtask

    // runs of mostly present, mostly absent or mixed samples
    function automatic logic [SAMPLE_BITS-1:0] next_sample();
        int lim;
        int r;
        logic want_present;
        if (run_left == 0)
        begin
            r = $urandom_range(19, 0);
            if (r < 10)
            begin
                run_kind = RUN_PRESENT;
                run_left = $urandom_range(90, 1);
            end
            else if (r < 17)
            begin
                run_kind = RUN_ABSENT;
                run_left = $urandom_range(45, 1);
            end
            else
            begin
                run_kind = RUN_NOISE;
                run_left = $urandom_range(8, 1);
            end
        end
        run_left--;
        case (run_kind)
            RUN_PRESENT: want_present = ($urandom_range(29, 0) != 0);
            RUN_ABSENT:  want_present = ($urandom_range(29, 0) == 0);
            default:     want_present = ($urandom_range(1, 0) != 0);
        endcase
        lim = (thr_now > 1024) ? 1024 : thr_now;
        if (want_present && lim > 0)
        begin
            if ($urandom_range(4, 0) == 0)
                return SAMPLE_BITS'(lim - 1);
            return SAMPLE_BITS'($urandom_range(lim - 1, 0));
        end
        if (!want_present && lim < 1024)
        begin
            if ($urandom_range(4, 0) == 0)
                return SAMPLE_BITS'(lim);
            return SAMPLE_BITS'($urandom_range(1023, lim));
        end
        return SAMPLE_BITS'($urandom_range(1023, 0));
    endfunction

    initial
    begin
        int seg;
        int seg_len;
        int random_sent;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        cfg_we        <= 1'b0;
        cfg_addr      <= CFG_THRESHOLD;
        cfg_wdata     <= '0;
        thr_now       = int'(RST_THRESHOLD);
        raised_now    = int'(RST_RAISED);
        burst_left    = 0;
        run_left      = 0;
        run_kind      = RUN_NOISE;
        random_sent   = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: field extremes and both sides of the threshold
        push_sample(10'd0);
        push_sample(10'd1023);
        push_sample(10'd102);
        push_sample(10'd103);
        settle();

        // zero dwell, floor at zero, zero load checks and zero departure count
        write_reg(CFG_THRESHOLD, 512);
        write_reg(CFG_RAISED, 2);
        write_reg(CFG_LOADING, 0);
        write_reg(CFG_DWELL, 0);
        write_reg(CFG_MOTOR, 255);
        write_reg(CFG_LOAD_CHK, 0);
        write_reg(CFG_DEPARTURE, 0);
        cfg_we <= 1'b0;
        repeat (10) push_sample(10'd0);
        settle();

        // raised position moved below the servo while loading
        write_reg(CFG_RAISED, 5);
        write_reg(CFG_LOADING, 3);
        write_reg(CFG_MOTOR, 1);
        write_reg(CFG_LOAD_CHK, 1);
        write_reg(CFG_DEPARTURE, 1);
        cfg_we <= 1'b0;
        repeat (4) push_sample(10'd0);
        settle();
        write_reg(CFG_RAISED, 0);
        cfg_we <= 1'b0;
        repeat (5) push_sample(10'd0);
        repeat (4) push_sample(10'd1023);
        settle();

        seg = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            settle();
            seg_len = $urandom_range(160, 40);
            case (seg)
                0:
                begin
                    // always present, loading at the start angle
                    write_reg(CFG_THRESHOLD, 1024);
                    write_reg(CFG_RAISED, 180);
                    write_reg(CFG_LOADING, 180);
                    write_reg(CFG_DWELL, 0);
                    write_reg(CFG_MOTOR, 0);
                    write_reg(CFG_LOAD_CHK, 2);
                    write_reg(CFG_DEPARTURE, 15);
                    cfg_we <= 1'b0;
                end
                1:
                begin
                    write_reg(CFG_THRESHOLD, 0);
                    write_reg(CFG_DWELL, 255);
                    write_reg(CFG_LOAD_CHK, 255);
                    cfg_we <= 1'b0;
                    seg_len = 20;
                end
                2:
                begin
                    write_reg(CFG_THRESHOLD, 512);
                    write_reg(CFG_RAISED, 60);
                    write_reg(CFG_LOADING, 52);
                    write_reg(CFG_DWELL, 3);
                    write_reg(CFG_LOAD_CHK, 4);
                    write_reg(CFG_DEPARTURE, 3);
                    write_reg(CFG_MOTOR, 200);
                    cfg_we <= 1'b0;
                end
                default:
                    if ($urandom_range(9, 0) < 7)
                        retune();
            endcase
            repeat (seg_len)
            begin
                push_sample(next_sample());
                random_sent++;
            end
            seg++;
        end

        settle();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("** presence_triggered_loader_sequencer_top: PASSED **");
        else
            $display("** presence_triggered_loader_sequencer_top: FAILED **");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/ptls_pkg.sv
hw/rtl/ptls_cfg.sv
hw/rtl/ptls_core.sv
hw/rtl/ptls_out_buf.sv
hw/rtl/presence_triggered_loader_sequencer_top.sv
hw/rtl/ptls_checker.sv
bench/ptls_actuation_checker.sv
bench/tb_presence_triggered_loader_sequencer_top.sv
